// ----- hdl/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 decoder: byte classes, code point
// limits and the command word passed from the front end to the back end.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned REP_W    = 3;   // up to four replacements
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QIDX_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
    localparam int unsigned TDATA_W  = 24;  // code point padded to bytes

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_MIN_2       = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3       = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4       = 21'h010000;

    // number of continuation bytes an open sequence needs
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    // work for the back end caused by one input byte:
    // rep copies of U+FFFD, then the value if has_value is set
    typedef struct packed {
        logic [REP_W-1:0] rep;
        logic             has_value;
        logic [CP_W-1:0]  value;
    } cmd_t;

endpackage

// ----- hdl/utf8_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_decoder
// Streaming UTF-8 decoder with validation: bytes in, code points out.
// ----------------------------------------------------------------------------
// channel   direction  tdata                    tlast
// s_*       in         [7:0] byte_req           -
// m_*       out        [20:0] codepoint         last result of a byte
//
// one byte accepted per cycle while the command queue has room; each byte
// gives zero to four result beats, one beat per cycle from the back end
// while m_tready is high. a byte with n results takes n beats, so bursts
// of replacements fill the four-entry queue and then hold s_tready low.
// reset clears the open sequence, the queue and the output stage; the first
// byte may be taken in the cycle after reset is released.
// ----------------------------------------------------------------------------
module utf8_decoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [utf8d_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] byte_req
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [utf8d_pkg::TDATA_W-1:0]   m_tdata,    // [20:0] codepoint
    output logic                            m_tlast     // last
);
    import utf8d_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_cmd;
    cmd_t head_cmd;

    // byte classification and sequence tracking
    utf8d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // command queue
    utf8d_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // result expansion
    utf8d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // queue never written when full
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // queue never read when empty
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("command popped from empty queue");

    // every queued command yields at least one and at most four results
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> ((q_cmd.rep != '0) || q_cmd.has_value) &&
                   ((q_cmd.rep + {2'b00, q_cmd.has_value}) <= 3'd4))
        else $error("command with bad result count");

endmodule

// ----- hdl/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// utf8d_front
// Input side: takes one byte per beat, tracks the open sequence and turns
// each byte into a command for the back end.
// ----------------------------------------------------------------------------
module utf8d_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [utf8d_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] byte_req
    input  logic                            q_full,
    output logic                            q_push,
    output utf8d_pkg::cmd_t                 q_cmd
);
    import utf8d_pkg::*;

    logic [1:0]      need_reg, need_next;
    logic [1:0]      seen_reg, seen_next;
    logic [CP_W-1:0] part_reg, part_next;

    logic            accept;
    logic            is_cont;
    logic [1:0]      seen_inc;
    logic [CP_W-1:0] part_shift;
    logic [CP_W-1:0] cp_min;
    logic            bad;
    cmd_t            cmd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign is_cont  = (s_tdata[7:6] == 2'b10);

    // continuation step and range checks
    assign seen_inc   = seen_reg + 2'd1;
    assign part_shift = {part_reg[CP_W-7:0], s_tdata[5:0]};

    always_comb
    begin
        unique case (need_reg)
            NEED_ONE: cp_min = CP_MIN_2;
            NEED_TWO: cp_min = CP_MIN_3;
            default:  cp_min = CP_MIN_4;
        endcase
    end

    assign bad = (part_shift < cp_min) ||
                 ((part_shift >= CP_SURR_LO) && (part_shift <= CP_SURR_HI)) ||
                 (part_shift > CP_MAX);

    // classify the byte and build the command
    always_comb
    begin
        need_next     = need_reg;
        seen_next     = seen_reg;
        part_next     = part_reg;
        cmd.rep       = '0;
        cmd.has_value = 1'b0;
        cmd.value     = {{(CP_W-BYTE_W){1'b0}}, s_tdata};
        if ((need_reg != NEED_NONE) && is_cont)
        begin
            part_next = part_shift;
            seen_next = seen_inc;
            if (seen_inc >= need_reg)
            begin
                if (bad)
                begin
                    cmd.rep = {1'b0, need_reg} + 3'd1;
                end
                else
                begin
                    cmd.has_value = 1'b1;
                    cmd.value     = part_shift;
                end
                need_next = NEED_NONE;
                seen_next = 2'd0;
                part_next = '0;
            end
        end
        else
        begin
            // broken sequence: lead and each seen continuation give U+FFFD
            if (need_reg != NEED_NONE)
                cmd.rep = {1'b0, seen_reg} + 3'd1;
            need_next = NEED_NONE;
            seen_next = 2'd0;
            part_next = '0;
            if (s_tdata == '0)
            begin
                // end of string, nothing more
            end
            else if (s_tdata[7] == 1'b0)
            begin
                cmd.has_value = 1'b1;
            end
            else if (s_tdata[7:5] == 3'b110)
            begin
                need_next = NEED_ONE;
                part_next = {{(CP_W-5){1'b0}}, s_tdata[4:0]};
            end
            else if (s_tdata[7:4] == 4'b1110)
            begin
                need_next = NEED_TWO;
                part_next = {{(CP_W-4){1'b0}}, s_tdata[3:0]};
            end
            else if (s_tdata[7:3] == 5'b11110)
            begin
                need_next = NEED_THREE;
                part_next = {{(CP_W-3){1'b0}}, s_tdata[2:0]};
            end
            else
            begin
                cmd.rep = cmd.rep + 3'd1;
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && ((cmd.rep != '0) || cmd.has_value);

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= NEED_NONE;
            seen_reg <= 2'd0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            need_reg <= need_next;
            seen_reg <= seen_next;
            part_reg <= part_next;
        end
    end

endmodule

// ----- hdl/utf8d_queue.sv -----
// ----------------------------------------------------------------------------
// utf8d_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module utf8d_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utf8d_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output utf8d_pkg::cmd_t head_cmd,
    output logic            empty
);
    import utf8d_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QIDX_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QIDX_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- hdl/utf8d_back.sv -----
// ----------------------------------------------------------------------------
// utf8d_back
// Output side: expands the head command into result beats, one per cycle
// while m_tready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module utf8d_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  utf8d_pkg::cmd_t                 head_cmd,
    input  logic                            q_empty,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [utf8d_pkg::TDATA_W-1:0]   m_tdata,    // [20:0] codepoint
    output logic                            m_tlast     // last
);
    import utf8d_pkg::*;

    logic [REP_W-1:0] done_reg, done_next;
    logic             valid_reg, valid_next;
    logic [CP_W-1:0]  cp_reg;
    logic             last_reg;

    logic             load;
    logic             emit_rep;
    logic [CP_W-1:0]  cp_sel;
    logic             last_sel;

    // pick the next result of the head command
    assign load     = !q_empty && (!valid_reg || m_tready);
    assign emit_rep = (head_cmd.rep > done_reg);
    assign cp_sel   = emit_rep ? CP_REPLACEMENT : head_cmd.value;
    assign last_sel = emit_rep ? ((done_reg + 3'd1 == head_cmd.rep) && !head_cmd.has_value)
                               : 1'b1;
    assign q_pop    = load && last_sel;

    always_comb
    begin
        if (q_pop)
            done_next = '0;
        else if (load)
            done_next = done_reg + 3'd1;
        else
            done_next = done_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= cp_sel;
            last_reg <= last_sel;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(TDATA_W-CP_W){1'b0}}, cp_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the UTF-8 decoder. A short table of hand-picked bytes is
// followed by random UTF-8 text: mostly well-formed sequences of every
// length, plus overlong, surrogate, out-of-range and truncated sequences and
// raw noise bytes. Every accepted byte goes through a software decoder
// that keeps its own open-sequence state and predicts the code point beats.
// Output beats are checked in order against those predictions. Both sides
// idle at random, the receiver stalls once for a long stretch and the
// sender stops twice before the end until all results are back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import utf8d_pkg::*;

    localparam int unsigned RAND_ITEMS     = 205;
    localparam int unsigned RX_HOLD_CYCLES = 200;
    localparam int unsigned TAIL_CYCLES    = 32;
    localparam int unsigned CYCLE_LIMIT    = 300000;
    localparam int unsigned SHOWN_ERRORS   = 10;

    localparam logic [CP_W-1:0] NO_CP = '0;
    localparam logic [CP_W-1:0] REP   = CP_REPLACEMENT;

    // one expected output beat
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
    } cp_beat_t;

    // one row of the directed table; known rows carry their results
    typedef struct packed {
        logic [7:0]                 data;
        logic                       known;
        logic [2:0]                 n;
        logic [0:3][CP_W-1:0]       cp;
    } stim_row_t;

    localparam stim_row_t DIR_ROWS [0:24] = '{
        '{8'h41, 1'b1, 3'd1, {21'h000041, NO_CP, NO_CP, NO_CP}},   // ascii
        '{8'h7F, 1'b1, 3'd1, {21'h00007F, NO_CP, NO_CP, NO_CP}},   // top ascii
        '{8'h00, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // end, idle
        '{8'h80, 1'b1, 3'd1, {REP, NO_CP, NO_CP, NO_CP}},          // stray cont
        '{8'hFF, 1'b1, 3'd1, {REP, NO_CP, NO_CP, NO_CP}},          // bad lead
        '{8'hF8, 1'b1, 3'd1, {REP, NO_CP, NO_CP, NO_CP}},          // bad lead
        '{8'hC2, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // two-byte
        '{8'hA9, 1'b0, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},
        '{8'hC0, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // overlong
        '{8'h80, 1'b1, 3'd2, {REP, REP, NO_CP, NO_CP}},
        '{8'hE2, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // three-byte
        '{8'h82, 1'b0, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},
        '{8'hAC, 1'b0, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},
        '{8'hED, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // surrogate
        '{8'hA0, 1'b0, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},
        '{8'h80, 1'b1, 3'd3, {REP, REP, REP, NO_CP}},
        '{8'hF4, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // above max
        '{8'h90, 1'b0, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},
        '{8'h80, 1'b0, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},
        '{8'h80, 1'b1, 3'd4, {REP, REP, REP, REP}},
        '{8'hF0, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // broken
        '{8'h9F, 1'b0, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},
        '{8'h41, 1'b1, 3'd3, {REP, REP, 21'h000041, NO_CP}},
        '{8'hE1, 1'b1, 3'd0, {NO_CP, NO_CP, NO_CP, NO_CP}},        // flush at end
        '{8'h00, 1'b1, 3'd1, {REP, NO_CP, NO_CP, NO_CP}}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;     // [7:0] byte_req
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;     // [20:0] codepoint
    logic                m_tlast;     // last

    // decoder state mirror
    logic [1:0]          open_need;
    logic [1:0]          open_seen;
    logic [CP_W-1:0]     open_cp;

    logic [CP_W-1:0]     step_cps [$];
    cp_beat_t            cp_expect [$];
    int unsigned         mismatches;
    int unsigned         cycle_cnt;
    bit                  rx_hold_req;
    bit                  tx_calm;

    utf8_decoder i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // decode one byte, advancing the mirrored state; results go to step_cps
    function automatic void decode_byte(input logic [7:0] b);
        logic [CP_W-1:0] floor_cp;
        int              reps;
        step_cps.delete();
        if (open_need != NEED_NONE) begin
            if (b[7:6] == 2'b10) begin
                open_cp   = {open_cp[CP_W-7:0], b[5:0]};
                open_seen = open_seen + 2'd1;
                if (open_seen >= open_need) begin
                    floor_cp = (open_need == NEED_ONE) ? CP_MIN_2 :
                               (open_need == NEED_TWO) ? CP_MIN_3 : CP_MIN_4;
                    if (open_cp < floor_cp || open_cp > CP_MAX ||
                        (open_cp >= CP_SURR_LO && open_cp <= CP_SURR_HI)) begin
                        reps = int'(open_need) + 1;
                        repeat (reps) step_cps.push_back(CP_REPLACEMENT);
                    end
                    else
                        step_cps.push_back(open_cp);
                    open_need = NEED_NONE;
                    open_seen = 2'd0;
                    open_cp   = '0;
                end
                return;
            end
            // broken sequence: lead and each buffered continuation
            reps = 1 + int'(open_seen);
            repeat (reps) step_cps.push_back(CP_REPLACEMENT);
            open_need = NEED_NONE;
            open_seen = 2'd0;
            open_cp   = '0;
        end
        if (b == 8'h00) begin
            // end of string, nothing emitted
        end
        else if (b[7] == 1'b0)
            step_cps.push_back(CP_W'(b));
        else if (b[7:5] == 3'b110) begin
            open_need = NEED_ONE;
            open_cp   = CP_W'(b[4:0]);
        end
        else if (b[7:4] == 4'b1110) begin
            open_need = NEED_TWO;
            open_cp   = CP_W'(b[3:0]);
        end
        else if (b[7:3] == 5'b11110) begin
            open_need = NEED_THREE;
            open_cp   = CP_W'(b[2:0]);
        end
        else
            step_cps.push_back(CP_REPLACEMENT);
    endfunction

    // move the results of the last byte into the expected store
    function automatic void queue_results();
        cp_beat_t beat;
        foreach (step_cps[k])
        begin
            beat.cp   = step_cps[k];
            beat.last = (k == step_cps.size() - 1);
            cp_expect.push_back(beat);
        end
    endfunction

    // utf-8 form of a value in len bytes; bits above the form are dropped
    function automatic void encode_cp(input logic [CP_W-1:0] cp, input int len,
                                      ref logic [7:0] seq [$]);
        case (len)
            2: seq.push_back({3'b110, cp[10:6]});
            3: seq.push_back({4'b1110, cp[15:12]});
            default:
            begin
                seq.push_back({5'b11110, cp[20:18]});
                seq.push_back({2'b10, cp[17:12]});
            end
        endcase
        if (len >= 3)
            seq.push_back({2'b10, cp[11:6]});
        seq.push_back({2'b10, cp[5:0]});
    endfunction

    // one random piece of text, mostly well-formed
    function automatic void gen_sequence(ref logic [7:0] seq [$]);
        int unsigned     pick;
        int              len;
        logic [CP_W-1:0] cp;
        seq.delete();
        pick = $urandom_range(0, 99);
        if (pick < 20)
            seq.push_back(8'($urandom_range(1, 127)));
        else if (pick < 35)
            encode_cp(CP_W'($urandom_range(32'h80, 32'h7FF)), 2, seq);
        else if (pick < 50)
            encode_cp(CP_W'($urandom_range(32'h800, 32'hFFFF)), 3, seq);
        else if (pick < 62)
            encode_cp(CP_W'($urandom_range(32'h10000, 32'h10FFFF)), 4, seq);
        else if (pick < 67)
            encode_cp(CP_W'($urandom()), 4, seq);     // any lead F0..F7
        else if (pick < 72)
        begin
            // overlong: value that fits a shorter form
            len = $urandom_range(2, 4);
            cp  = (len == 2) ? CP_W'($urandom_range(0, 32'h7F)) :
                  (len == 3) ? CP_W'($urandom_range(0, 32'h7FF)) :
                               CP_W'($urandom_range(0, 32'hFFFF));
            encode_cp(cp, len, seq);
        end
        else if (pick < 77)
            encode_cp(CP_W'($urandom_range(32'hD800, 32'hDFFF)), 3, seq);
        else if (pick < 87)
        begin
            // truncated sequence broken by a non-continuation byte
            len = $urandom_range(2, 4);
            encode_cp(CP_W'($urandom()), len, seq);
            repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
            if ($urandom_range(0, 1) == 0)
                seq.push_back(8'($urandom_range(0, 127)));
            else
                seq.push_back(8'($urandom_range(8'hC0, 8'hFF)));
        end
        else if (pick < 97)
            seq.push_back(8'($urandom_range(0, 255)));
        else
            seq.push_back(8'h00);
    endfunction

    // offer one byte and wait for its beat
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // drop valid and wait until every expected beat is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (cp_expect.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input logic [CP_W-1:0] exp_cp,
                                 input logic exp_last);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("mismatch (%s): expected cp %h last %b, got tdata %h last %b",
                     what, exp_cp, exp_last, m_tdata, m_tlast);
    endtask

    // output checker
    always @(posedge clk)
    begin
        cp_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cp_expect.size() == 0)
                flag_mismatch("no beat expected", NO_CP, 1'b0);
            else
            begin
                want = cp_expect.pop_front();
                if (m_tdata != TDATA_W'(want.cp) || m_tlast != want.last)
                    flag_mismatch("wrong beat", want.cp, want.last);
            end
        end
    end

    // receiver: random ready with one long hold on request
    initial
    begin
        int run;
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                run = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 24);
                m_tready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // run limit
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [7:0]  seq [$];
        int unsigned rand_sent;
        int          k;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        open_need   = NEED_NONE;
        open_seen   = 2'd0;
        open_cp     = '0;
        mismatches  = 0;
        rx_hold_req = 1'b0;
        tx_calm     = 1'b0;
        rand_sent   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (DIR_ROWS[i])
        begin
            send_byte(DIR_ROWS[i].data);
            decode_byte(DIR_ROWS[i].data);
            if (DIR_ROWS[i].known)
            begin
                step_cps.delete();
                for (k = 0; k < int'(DIR_ROWS[i].n); k++)
                    step_cps.push_back(DIR_ROWS[i].cp[k]);
            end
            queue_results();
        end
        drain_results();

        // random text
        while (rand_sent < RAND_ITEMS)
        begin
            gen_sequence(seq);
            tx_calm = ($urandom_range(0, 5) == 0);
            foreach (seq[j])
            begin
                send_byte(seq[j]);
                decode_byte(seq[j]);
                queue_results();
                rand_sent++;
                if (rand_sent == 80)
                    rx_hold_req = 1'b1;
                if (rand_sent == 160)
                    drain_results();
            end
        end

        // wrap up
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/utf8d_pkg.sv
hdl/utf8d_front.sv
hdl/utf8d_queue.sv
hdl/utf8d_back.sv
hdl/utf8_decoder.sv
dv/tb_top.sv
